### src/mesh_dimension_order_router_unit_defines.svh
// ----------------------------------------------------------------------------
// Mesh router assertion macros
// Shared concurrent assertion forms for the router checker.
// ----------------------------------------------------------------------------
`ifndef MESH_DIMENSION_ORDER_ROUTER_UNIT_DEFINES_SVH
`define MESH_DIMENSION_ORDER_ROUTER_UNIT_DEFINES_SVH

// same-cycle implication
`define MDOR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MDOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mdor_pkg.sv
// ----------------------------------------------------------------------------
// Mesh router package
// Payload types, register codes and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdor_pkg;

  localparam int unsigned MAX_MESH_SIZE   = 16;
  localparam int unsigned MAX_LINK_WIDTH  = 4;
  localparam int unsigned MAX_LOCAL_PORTS = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [2:0] CFG_BOARD_ID     = 3'd0;
  localparam logic [2:0] CFG_ROUTER_INDEX = 3'd1;
  localparam logic [2:0] CFG_SIZE_X       = 3'd2;
  localparam logic [2:0] CFG_SIZE_Y       = 3'd3;
  localparam logic [2:0] CFG_WIDTH_X      = 3'd4;
  localparam logic [2:0] CFG_WIDTH_Y      = 3'd5;
  localparam logic [2:0] CFG_LOCAL_PORTS  = 3'd6;

  // x mod 3 for x in 0..15, two bits per entry
  localparam logic [31:0] MOD3_LUT = 32'h2492_4924;

  typedef enum logic [1:0] {
    ST_MESH        = 2'd0,
    ST_LOCAL       = 2'd1,
    ST_OTHER_BOARD = 2'd2,
    ST_NONE        = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] dest_endpoint;
    logic [4:0]  in_port;
    logic [3:0]  in_vc;
    logic [1:0]  in_dim;
  } in_t;

  typedef struct packed {
    logic [4:0] route_port;
    logic [3:0] out_vc;
    logic [1:0] out_dim;
    status_t    status;
  } out_t;

  // register values after saturation
  typedef struct packed {
    logic [7:0]  board_id;
    logic [11:0] router_index;
    logic [4:0]  sx;
    logic [4:0]  sy;
    logic [2:0]  wx;
    logic [2:0]  wy;
    logic [3:0]  lp;
  } cfg_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [5:0] div_step(input logic [4:0] rem, input logic b,
                                          input logic [4:0] d);
    logic [5:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      return {1'b1, 5'(t - {1'b0, d})};
    end else begin
      return {1'b0, t[4:0]};
    end
  endfunction

  // link choice inside a group: hop_len mod w, w in 1..4
  function automatic logic [1:0] mod_width(input logic [3:0] hop_len, input logic [2:0] w);
    case (w)
      3'd2:    return {1'b0, hop_len[0]};
      3'd3:    return MOD3_LUT[{hop_len, 1'b0} +: 2];
      3'd4:    return hop_len[1:0];
      default: return 2'd0;
    endcase
  endfunction

endpackage

### src/mdor_cfg.sv
// ----------------------------------------------------------------------------
// Mesh router configuration registers
// Register file with saturation of sizes, widths and port counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdor_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mdor_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdor_pkg::CFG_DATA_W-1:0] cfg_data,
  output mdor_pkg::cfg_t                  cfg
);
  import mdor_pkg::*;

  logic [7:0]  board_id;
  logic [11:0] router_index;
  logic [4:0]  size_x;
  logic [4:0]  size_y;
  logic [2:0]  width_x;
  logic [2:0]  width_y;
  logic [3:0]  lport_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_id     <= 8'd0;
      router_index <= 12'd0;
      size_x       <= 5'd4;
      size_y       <= 5'd4;
      width_x      <= 3'd1;
      width_y      <= 3'd1;
      lport_cnt    <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BOARD_ID:     board_id     <= cfg_data[7:0];
        CFG_ROUTER_INDEX: router_index <= cfg_data[11:0];
        CFG_SIZE_X:       size_x       <= cfg_data[4:0];
        CFG_SIZE_Y:       size_y       <= cfg_data[4:0];
        CFG_WIDTH_X:      width_x      <= cfg_data[2:0];
        CFG_WIDTH_Y:      width_y      <= cfg_data[2:0];
        CFG_LOCAL_PORTS:  lport_cnt    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.board_id     = board_id;
    cfg.router_index = router_index;
    cfg.sx = (size_x == 5'd0) ? 5'd1 :
             (size_x > 5'(MAX_MESH_SIZE)) ? 5'(MAX_MESH_SIZE) : size_x;
    cfg.sy = (size_y == 5'd0) ? 5'd1 :
             (size_y > 5'(MAX_MESH_SIZE)) ? 5'(MAX_MESH_SIZE) : size_y;
    cfg.wx = (width_x == 3'd0) ? 3'd1 :
             (width_x > 3'(MAX_LINK_WIDTH)) ? 3'(MAX_LINK_WIDTH) : width_x;
    cfg.wy = (width_y == 3'd0) ? 3'd1 :
             (width_y > 3'(MAX_LINK_WIDTH)) ? 3'(MAX_LINK_WIDTH) : width_y;
    cfg.lp = (lport_cnt == 4'd0) ? 4'd1 :
             (lport_cnt > 4'(MAX_LOCAL_PORTS)) ? 4'(MAX_LOCAL_PORTS) : lport_cnt;
  end

endmodule

### src/mdor_pipe.sv
// ----------------------------------------------------------------------------
// Mesh router pipeline
// Five-stage route pipeline: division steps, board check, coordinates,
// port choice. Per-stage valid bits with bubble collapse under stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdor_pipe (
  input  logic           clk,
  input  logic           rst,
  input  mdor_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  mdor_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mdor_pkg::out_t out_data
);
  import mdor_pkg::*;

  logic [4:0] lp5;
  logic [4:0] sx5;
  logic [4:0] sy5;
  logic [4:0] lstart;

  assign lp5    = {1'b0, cfg.lp};
  assign sx5    = cfg.sx;
  assign sy5    = cfg.sy;
  assign lstart = {1'b0, cfg.wx, 1'b0} + {1'b0, cfg.wy, 1'b0};

  logic [5:1] v;
  logic [5:1] en;

  assign en[5] = !v[5] || !out_stall;
  assign en[4] = !v[4] || en[5];
  assign en[3] = !v[3] || en[4];
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign in_stall  = !en[1];
  assign out_valid = v[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
      if (en[5]) v[5] <= v[4];
    end
  end

  // ---- stage 1: upper quotient bits of dest / lp and router_index / sx
  in_t        s1_d;
  logic [7:0] s1_dq;
  logic [4:0] s1_drem;
  logic [5:0] s1_rq;
  logic [4:0] s1_rrem;
  logic [8:0] s1_sxy;

  logic [7:0] c1_dq;
  logic [4:0] c1_drem;
  logic [5:0] c1_rq;
  logic [4:0] c1_rrem;
  logic [5:0] c1_st;

  always_comb begin
    c1_drem = 5'd0;
    c1_dq   = 8'd0;
    for (int i = 0; i < 8; i++) begin
      c1_st        = div_step(c1_drem, in_data.dest_endpoint[15-i], lp5);
      c1_dq[7-i]   = c1_st[5];
      c1_drem      = c1_st[4:0];
    end
    c1_rrem = 5'd0;
    c1_rq   = 6'd0;
    for (int i = 0; i < 6; i++) begin
      c1_st        = div_step(c1_rrem, cfg.router_index[11-i], sx5);
      c1_rq[5-i]   = c1_st[5];
      c1_rrem      = c1_st[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d    <= in_data;
      s1_dq   <= c1_dq;
      s1_drem <= c1_drem;
      s1_rq   <= c1_rq;
      s1_rrem <= c1_rrem;
      s1_sxy  <= {4'd0, sx5} * {4'd0, sy5};
    end
  end

  // ---- stage 2: lower quotient bits, board base
  in_t         s2_d;
  logic [15:0] s2_dr;
  logic [2:0]  s2_lrem;
  logic [11:0] s2_riq;
  logic [3:0]  s2_own0;
  logic [8:0]  s2_sxy;
  logic [16:0] s2_base;

  logic [7:0] c2_dq;
  logic [4:0] c2_drem;
  logic [5:0] c2_rq;
  logic [4:0] c2_rrem;
  logic [5:0] c2_st;

  always_comb begin
    c2_drem = s1_drem;
    c2_dq   = 8'd0;
    for (int i = 0; i < 8; i++) begin
      c2_st        = div_step(c2_drem, s1_d.dest_endpoint[7-i], lp5);
      c2_dq[7-i]   = c2_st[5];
      c2_drem      = c2_st[4:0];
    end
    c2_rrem = s1_rrem;
    c2_rq   = 6'd0;
    for (int i = 0; i < 6; i++) begin
      c2_st        = div_step(c2_rrem, cfg.router_index[5-i], sx5);
      c2_rq[5-i]   = c2_st[5];
      c2_rrem      = c2_st[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_d    <= s1_d;
      s2_dr   <= {s1_dq, c2_dq};
      s2_lrem <= c2_drem[2:0];
      s2_riq  <= {s1_rq, c2_rq};
      s2_own0 <= c2_rrem[3:0];
      s2_sxy  <= s1_sxy;
      s2_base <= {9'd0, cfg.board_id} * {8'd0, s1_sxy};
    end
  end

  // ---- stage 3: board check, start of coordinate division
  // local / sx stays below sy, so only the remainder is carried here
  in_t        s3_d;
  logic [2:0] s3_lrem;
  logic       s3_board_ok;
  logic       s3_is_local;
  logic [3:0] s3_own0;
  logic [4:0] s3_orem;
  logic [5:0] s3_riq_lo;
  logic [4:0] s3_lrem_div;
  logic [3:0] s3_loc_lo;

  logic [16:0] c3_dr;
  logic        c3_board_ok;
  logic [7:0]  c3_loc;
  logic [4:0]  c3_orem;
  logic [4:0]  c3_lr;
  logic [5:0]  c3_st;

  always_comb begin
    c3_dr       = {1'b0, s2_dr};
    c3_board_ok = (c3_dr >= s2_base) && (c3_dr < s2_base + {8'd0, s2_sxy});
    c3_loc      = 8'(c3_dr - s2_base);
    c3_orem     = 5'd0;
    for (int i = 0; i < 6; i++) begin
      c3_st   = div_step(c3_orem, s2_riq[11-i], sy5);
      c3_orem = c3_st[4:0];
    end
    c3_lr = 5'd0;
    for (int i = 0; i < 4; i++) begin
      c3_st = div_step(c3_lr, c3_loc[7-i], sx5);
      c3_lr = c3_st[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_d        <= s2_d;
      s3_lrem     <= s2_lrem;
      s3_board_ok <= c3_board_ok;
      s3_is_local <= (s2_dr == {4'd0, cfg.router_index});
      s3_own0     <= s2_own0;
      s3_orem     <= c3_orem;
      s3_riq_lo   <= s2_riq[5:0];
      s3_lrem_div <= c3_lr;
      s3_loc_lo   <= c3_loc[3:0];
    end
  end

  // ---- stage 4: coordinates of this and the destination router
  in_t        s4_d;
  logic [2:0] s4_lrem;
  logic       s4_board_ok;
  logic       s4_is_local;
  logic [3:0] s4_own0;
  logic [3:0] s4_own1;
  logic [3:0] s4_dst0;
  logic [3:0] s4_dst1;

  logic [4:0] c4_orem;
  logic [3:0] c4_lq;
  logic [4:0] c4_lr;
  logic [5:0] c4_st;

  always_comb begin
    c4_orem = s3_orem;
    for (int i = 0; i < 6; i++) begin
      c4_st   = div_step(c4_orem, s3_riq_lo[5-i], sy5);
      c4_orem = c4_st[4:0];
    end
    c4_lr = s3_lrem_div;
    c4_lq = 4'd0;
    for (int i = 0; i < 4; i++) begin
      c4_st      = div_step(c4_lr, s3_loc_lo[3-i], sx5);
      c4_lq[3-i] = c4_st[5];
      c4_lr      = c4_st[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_d        <= s3_d;
      s4_lrem     <= s3_lrem;
      s4_board_ok <= s3_board_ok;
      s4_is_local <= s3_is_local;
      s4_own0     <= s3_own0;
      s4_own1     <= c4_orem[3:0];
      s4_dst0     <= c4_lr[3:0];
      s4_dst1     <= c4_lq;
    end
  end

  // ---- stage 5: port choice
  logic [3:0] own [2];
  logic [3:0] dst [2];
  logic [2:0] wid [2];
  logic [4:0] pp  [2];
  logic [4:0] pn  [2];
  logic       done;
  logic       pos;
  logic [3:0] hop_len;
  out_t       res;

  always_comb begin
    own[0] = s4_own0;
    own[1] = s4_own1;
    dst[0] = s4_dst0;
    dst[1] = s4_dst1;
    wid[0] = cfg.wx;
    wid[1] = cfg.wy;
    pp[0]  = 5'd0;
    pn[0]  = {2'd0, cfg.wx};
    pp[1]  = {1'b0, cfg.wx, 1'b0};
    pn[1]  = {1'b0, cfg.wx, 1'b0} + {2'd0, cfg.wy};
    done    = 1'b0;
    pos     = 1'b0;
    hop_len = 4'd0;
    res.route_port = 5'd0;
    res.out_vc     = s4_d.in_vc;
    res.out_dim    = s4_d.in_dim;
    res.status     = ST_NONE;
    if (!s4_board_ok) begin
      res.status = ST_OTHER_BOARD;
    end else if (s4_is_local) begin
      res.route_port = lstart + {2'd0, s4_lrem};
      res.status     = ST_LOCAL;
    end else begin
      for (int k = 0; k < 2; k++) begin
        if (!done && (2'(k) >= s4_d.in_dim)) begin
          if (dst[k] != own[k]) begin
            pos     = own[k] < dst[k];
            hop_len = pos ? dst[k] - own[k] : own[k] - dst[k];
            res.route_port = (pos ? pp[k] : pn[k]) + {3'd0, mod_width(hop_len, wid[k])};
            if (own[k] == 4'd0 && s4_d.in_port < lstart) begin
              res.out_vc = s4_d.in_vc ^ 4'd1;
            end
            res.status = ST_MESH;
            done = 1'b1;
          end else begin
            res.out_dim = 2'(k + 1);
            res.out_vc  = s4_d.in_vc & ~4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      out_data <= res;
    end
  end

endmodule

### src/mesh_dimension_order_router_unit.sv
// ----------------------------------------------------------------------------
// Mesh dimension-order router
// X-then-Y output port choice for one router of a 2D mesh.
// ----------------------------------------------------------------------------
// One route decision per packet header, one header accepted every cycle
// unless in_stall is high. The result passes through the five register
// stages of the route pipeline (two for the endpoint divide, two
// for the coordinate divides, one for the port choice). A held output
// stalls only the stages behind it that are full; empty stages still take
// new headers. Configuration writes are taken in any cycle and must only
// be issued while no header is in flight.
`timescale 1ns / 1ps

module mesh_dimension_order_router_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mdor_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mdor_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mdor_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdor_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mdor_pkg::*;

  cfg_t cfg;

  mdor_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdor_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### src/mdor_checker.sv
// ----------------------------------------------------------------------------
// Mesh router checker
// Port-level assertions, bound to the router top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mesh_dimension_order_router_unit_defines.svh"

module mdor_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input mdor_pkg::out_t out_data
);
  import mdor_pkg::*;

  `MDOR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")
  `MDOR_ASSERT_NOW(a_no_stall_empty, !out_valid, !in_stall, "input stalled with output empty")
  `MDOR_ASSERT_NOW(a_port_zero, out_valid && (out_data.status == ST_OTHER_BOARD || out_data.status == ST_NONE), out_data.route_port == 5'd0, "port set without a route")
  `MDOR_ASSERT_NOW(a_dim_mesh, out_valid && out_data.status == ST_MESH, out_data.out_dim <= 2'd1, "dimension out of range on mesh transfer")

endmodule

bind mesh_dimension_order_router_unit mdor_checker u_mdor_checker (.*);
